// File: hw/rtl/wvnf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wvnf_pkg;

    // Field widths of the items.
    localparam int SUM_W = 32;
    localparam int SQ_W  = 48;
    localparam int STD_W = 24;

    // The window is 18 by 18 pixels.
    localparam int WIN_AREA = 324;
    localparam int AREA_W   = 9;

    // Widths inside the datapath.
    localparam int Q324_W = 58;
    localparam int SSQ_W  = 2 * SUM_W;
    localparam int DIFF_W = 64;
    localparam int RAD_W  = 56;
    localparam int ROOT_W = 44;
    localparam int REM_W  = ROOT_W + 3;

    // Pipeline shape.
    localparam int FRONT_STAGES = 4;
    localparam int SQRT_STEPS   = 2;
    localparam int SQRT_STAGES  = ROOT_W / SQRT_STEPS;
    localparam int DIV_STEPS    = 6;
    localparam int DIV_STAGES   = STD_W / DIV_STEPS;

    localparam logic [STD_W-1:0]  ONE_Q16   = STD_W'(65536);
    localparam logic [STD_W-1:0]  STD_MAX   = '1;
    localparam logic [ROOT_W-1:0] SAT_LIMIT = ROOT_W'(WIN_AREA) << STD_W;
    localparam logic [AREA_W:0]   AREA_DIV  = (AREA_W + 1)'(WIN_AREA);

    typedef struct packed {
        logic [SUM_W-1:0] sum_top_left;
        logic [SUM_W-1:0] sum_top_right;
        logic [SUM_W-1:0] sum_bottom_left;
        logic [SUM_W-1:0] sum_bottom_right;
        logic [SQ_W-1:0]  sq_top_left;
        logic [SQ_W-1:0]  sq_top_right;
        logic [SQ_W-1:0]  sq_bottom_left;
        logic [SQ_W-1:0]  sq_bottom_right;
    } window_t;

    typedef struct packed {
        logic [STD_W-1:0] std_dev_q16;
        logic             variance_was_negative;
    } result_t;

    // State of the digit-by-digit square root.
    typedef struct packed {
        logic              neg;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_t;

    typedef struct packed {
        logic              neg;
        logic [ROOT_W-1:0] root;
    } root_t;

    // State of the long division by the window area.
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [AREA_W-1:0] rem;
        logic [STD_W-1:0]  dvd;
        logic [STD_W-1:0]  quot;
    } div_t;

endpackage

`default_nettype wire

// File: hw/rtl/wvnf_win_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wvnf_win_if;
    logic              valid;
    logic              ready;
    wvnf_pkg::window_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wvnf_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface wvnf_res_if;
    logic              valid;
    logic              ready;
    wvnf_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wvnf_front.sv
`timescale 1ns / 1ps
`default_nettype none

module wvnf_front (
    input  wire logic       clk,
    input  wire logic       rst_n,
    wvnf_win_if.sink        window,
    output wvnf_pkg::sqrt_t sq_data,
    output logic            sq_valid,
    input  wire logic       sq_ready
);

    logic [wvnf_pkg::FRONT_STAGES-1:0] vld_reg;
    logic [wvnf_pkg::FRONT_STAGES-1:0] vld_src;
    logic [wvnf_pkg::FRONT_STAGES-1:0] en;

    logic [wvnf_pkg::SUM_W-1:0]  s_next, s_reg;
    logic [wvnf_pkg::SQ_W-1:0]   q_next, q_reg;
    logic [wvnf_pkg::SUM_W-1:0]  sabs_next, sabs_reg;
    logic [wvnf_pkg::Q324_W-1:0] q324_next, q324_reg, q324b_reg;
    logic [wvnf_pkg::SSQ_W-1:0]  ssq_next, ssq_reg;
    logic [wvnf_pkg::DIFF_W-1:0] diff_next;
    logic                        neg_reg;
    logic [wvnf_pkg::RAD_W-1:0]  rad_reg;

    // A stage may load when it or any stage after it is empty, or the
    // consumer takes an item.
    always_comb
    begin
        for (int i = 0; i < wvnf_pkg::FRONT_STAGES; i++)
        begin
            en[i] = sq_ready |
                ((~vld_reg & ({wvnf_pkg::FRONT_STAGES{1'b1}} << i)) != '0);
        end
    end

    assign vld_src      = {vld_reg[wvnf_pkg::FRONT_STAGES-2:0], window.valid};
    assign window.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < wvnf_pkg::FRONT_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_src[i];
                end
            end
        end
    end

    // Box sums wrap at their own widths.
    assign s_next = window.data.sum_top_left - window.data.sum_top_right
                  - window.data.sum_bottom_left + window.data.sum_bottom_right;
    assign q_next = window.data.sq_top_left - window.data.sq_top_right
                  - window.data.sq_bottom_left + window.data.sq_bottom_right;

    // The magnitude of the most negative sum still fits unsigned.
    assign sabs_next = s_reg[wvnf_pkg::SUM_W-1] ? (~s_reg + wvnf_pkg::SUM_W'(1)) : s_reg;
    assign q324_next = wvnf_pkg::Q324_W'($signed(q_reg))
                     * wvnf_pkg::Q324_W'(wvnf_pkg::WIN_AREA);

    assign ssq_next  = wvnf_pkg::SSQ_W'(sabs_reg) * wvnf_pkg::SSQ_W'(sabs_reg);

    assign diff_next = wvnf_pkg::DIFF_W'($signed(q324b_reg)) - ssq_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg <= s_next;
            q_reg <= q_next;
        end
        if (en[1])
        begin
            sabs_reg <= sabs_next;
            q324_reg <= q324_next;
        end
        if (en[2])
        begin
            ssq_reg   <= ssq_next;
            q324b_reg <= q324_reg;
        end
        if (en[3])
        begin
            neg_reg <= diff_next[wvnf_pkg::DIFF_W-1];
            rad_reg <= diff_next[wvnf_pkg::RAD_W-1:0];
        end
    end

    assign sq_valid     = vld_reg[wvnf_pkg::FRONT_STAGES-1];
    assign sq_data.neg  = neg_reg;
    assign sq_data.rad  = rad_reg;
    assign sq_data.rem  = '0;
    assign sq_data.root = '0;

endmodule

`default_nettype wire

// File: hw/rtl/wvnf_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module wvnf_sqrt (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wvnf_pkg::sqrt_t in_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    output wvnf_pkg::root_t out_data,
    output logic            out_valid,
    input  wire logic       out_ready
);

    // One root digit: bring down the next pair of radicand bits and try
    // to subtract four times the root plus one.
    function automatic wvnf_pkg::sqrt_t sqrt_step(input wvnf_pkg::sqrt_t x);
        wvnf_pkg::sqrt_t                y;
        logic [wvnf_pkg::REM_W-1:0]     rem_sh;
        logic [wvnf_pkg::REM_W-1:0]     trial;
        y      = x;
        rem_sh = {x.rem[wvnf_pkg::REM_W-3:0], x.rad[wvnf_pkg::RAD_W-1 -: 2]};
        trial  = wvnf_pkg::REM_W'({x.root, 2'b01});
        y.rad  = {x.rad[wvnf_pkg::RAD_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            y.rem  = rem_sh - trial;
            y.root = {x.root[wvnf_pkg::ROOT_W-2:0], 1'b1};
        end
        else
        begin
            y.rem  = rem_sh;
            y.root = {x.root[wvnf_pkg::ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    logic [wvnf_pkg::SQRT_STAGES-1:0] vld_reg;
    logic [wvnf_pkg::SQRT_STAGES-1:0] vld_src;
    logic [wvnf_pkg::SQRT_STAGES-1:0] en;
    wvnf_pkg::sqrt_t                  st_reg  [wvnf_pkg::SQRT_STAGES];
    wvnf_pkg::sqrt_t                  st_src  [wvnf_pkg::SQRT_STAGES];
    wvnf_pkg::sqrt_t                  st_next [wvnf_pkg::SQRT_STAGES];

    always_comb
    begin
        for (int i = 0; i < wvnf_pkg::SQRT_STAGES; i++)
        begin
            en[i] = out_ready |
                ((~vld_reg & ({wvnf_pkg::SQRT_STAGES{1'b1}} << i)) != '0);
        end
    end

    assign vld_src  = {vld_reg[wvnf_pkg::SQRT_STAGES-2:0], in_valid};
    assign in_ready = en[0];

    always_comb
    begin
        st_src[0] = in_data;
        for (int i = 1; i < wvnf_pkg::SQRT_STAGES; i++)
        begin
            st_src[i] = st_reg[i-1];
        end
    end

    always_comb
    begin
        wvnf_pkg::sqrt_t tmp;
        for (int i = 0; i < wvnf_pkg::SQRT_STAGES; i++)
        begin
            tmp = st_src[i];
            for (int b = 0; b < wvnf_pkg::SQRT_STEPS; b++)
            begin
                tmp = sqrt_step(tmp);
            end
            st_next[i] = tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < wvnf_pkg::SQRT_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_src[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wvnf_pkg::SQRT_STAGES; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid     = vld_reg[wvnf_pkg::SQRT_STAGES-1];
    assign out_data.neg  = st_reg[wvnf_pkg::SQRT_STAGES-1].neg;
    assign out_data.root = st_reg[wvnf_pkg::SQRT_STAGES-1].root;

endmodule

`default_nettype wire

// File: hw/rtl/wvnf_div.sv
`timescale 1ns / 1ps
`default_nettype none

module wvnf_div (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wvnf_pkg::root_t in_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    wvnf_res_if.source      result
);

    // One quotient bit of the restoring division by the window area.
    function automatic wvnf_pkg::div_t div_step(input wvnf_pkg::div_t x);
        wvnf_pkg::div_t              y;
        logic [wvnf_pkg::AREA_W:0]   r;
        y     = x;
        r     = {x.rem, x.dvd[wvnf_pkg::STD_W-1]};
        y.dvd = {x.dvd[wvnf_pkg::STD_W-2:0], 1'b0};
        if (r >= wvnf_pkg::AREA_DIV)
        begin
            y.rem  = wvnf_pkg::AREA_W'(r - wvnf_pkg::AREA_DIV);
            y.quot = {x.quot[wvnf_pkg::STD_W-2:0], 1'b1};
        end
        else
        begin
            y.rem  = r[wvnf_pkg::AREA_W-1:0];
            y.quot = {x.quot[wvnf_pkg::STD_W-2:0], 1'b0};
        end
        return y;
    endfunction

    logic [wvnf_pkg::DIV_STAGES-1:0] vld_reg;
    logic [wvnf_pkg::DIV_STAGES-1:0] vld_src;
    logic [wvnf_pkg::DIV_STAGES-1:0] en;
    wvnf_pkg::div_t                  prep;
    wvnf_pkg::div_t                  last;
    wvnf_pkg::div_t                  st_reg  [wvnf_pkg::DIV_STAGES];
    wvnf_pkg::div_t                  st_src  [wvnf_pkg::DIV_STAGES];
    wvnf_pkg::div_t                  st_next [wvnf_pkg::DIV_STAGES];

    always_comb
    begin
        for (int i = 0; i < wvnf_pkg::DIV_STAGES; i++)
        begin
            en[i] = result.ready |
                ((~vld_reg & ({wvnf_pkg::DIV_STAGES{1'b1}} << i)) != '0);
        end
    end

    assign vld_src  = {vld_reg[wvnf_pkg::DIV_STAGES-2:0], in_valid};
    assign in_ready = en[0];

    // Below the saturation limit the root's upper bits are already less
    // than the divisor, so they seed the partial remainder directly.
    always_comb
    begin
        prep.neg  = in_data.neg;
        prep.sat  = (in_data.root >= wvnf_pkg::SAT_LIMIT);
        prep.rem  = in_data.root[wvnf_pkg::STD_W+wvnf_pkg::AREA_W-1:wvnf_pkg::STD_W];
        prep.dvd  = in_data.root[wvnf_pkg::STD_W-1:0];
        prep.quot = '0;
    end

    always_comb
    begin
        st_src[0] = prep;
        for (int i = 1; i < wvnf_pkg::DIV_STAGES; i++)
        begin
            st_src[i] = st_reg[i-1];
        end
    end

    always_comb
    begin
        wvnf_pkg::div_t tmp;
        for (int i = 0; i < wvnf_pkg::DIV_STAGES; i++)
        begin
            tmp = st_src[i];
            for (int b = 0; b < wvnf_pkg::DIV_STEPS; b++)
            begin
                tmp = div_step(tmp);
            end
            st_next[i] = tmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < wvnf_pkg::DIV_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_src[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < wvnf_pkg::DIV_STAGES; i++)
        begin
            if (en[i])
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign last         = st_reg[wvnf_pkg::DIV_STAGES-1];
    assign result.valid = vld_reg[wvnf_pkg::DIV_STAGES-1];

    always_comb
    begin
        result.data.variance_was_negative = last.neg;
        if (last.neg)
        begin
            result.data.std_dev_q16 = wvnf_pkg::ONE_Q16;
        end
        else if (last.sat)
        begin
            result.data.std_dev_q16 = wvnf_pkg::STD_MAX;
        end
        else
        begin
            result.data.std_dev_q16 = last.quot;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/window_variance_norm_factor_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Payload                                 Handshake
// window    in         four integral and four squared corners   valid / ready
// result    out        std_dev_q16, variance_was_negative       valid / ready
//
// One item is taken per cycle while result.ready is high or a stage is empty: four
// stages form the box sums, the squared sum and the variance numerator, 22
// stages compute the square root at two root bits per stage, and four stages
// divide by the window area at six quotient bits per stage.
// Reset clears only the valid bits of the stages; the data registers are not reset.
// When the result is not taken, items keep moving forward into empty stages, so
// the input stays ready until every stage holds an item.

module window_variance_norm_factor_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    wvnf_win_if.sink   window,
    wvnf_res_if.source result
);

    // Numerator of the variance, d = 324 * Q - S * S, with its sign.
    wvnf_pkg::sqrt_t front_data;
    logic            front_valid;
    logic            front_ready;

    // Square root of d scaled by 2^32, which is sqrt(d) scaled by 2^16.
    wvnf_pkg::root_t root_data;
    logic            root_valid;
    logic            root_ready;

    wvnf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .window   (window),
        .sq_data  (front_data),
        .sq_valid (front_valid),
        .sq_ready (front_ready)
    );

    wvnf_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (front_data),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_data  (root_data),
        .out_valid (root_valid),
        .out_ready (root_ready)
    );

    // The divider also applies saturation and the negative-variance override.
    wvnf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (root_data),
        .in_valid (root_valid),
        .in_ready (root_ready),
        .result   (result)
    );

endmodule

`default_nettype wire
